/* hw/rtl/clhm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clhm_pkg;

  localparam int DEF_HISTORY_DEPTH = 10;
  localparam int DEF_GROUP_SIZE    = 4;

  localparam int LOAD_W   = 7;
  localparam int SUM_W    = 9;
  localparam int MARGIN_W = 7;
  localparam int LMARGIN_W = 10;
  localparam int WIN_W    = 4;
  localparam int CFG_W    = 10;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // newest entries averaged into the smoothed loads
  localparam int SMOOTH_TAPS = 4;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [MARGIN_W-1:0]  RST_CRIT_MARGIN = 7'd90;
  localparam logic [LMARGIN_W-1:0] RST_LOAD_MARGIN = 10'd200;
  localparam logic [WIN_W-1:0]     RST_WINDOW      = 4'd3;

  typedef enum logic [1:0] {
    CFG_LITTLE_CRIT_MARGIN = 2'd0,
    CFG_BIG_CRIT_MARGIN    = 2'd1,
    CFG_LOADING_MARGIN     = 2'd2,
    CFG_WINDOW_LENGTH      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic               cluster_sel;
    logic [LOAD_W-1:0]  core_load;
  } sample_t;

  typedef struct packed {
    logic [SUM_W-1:0] smoothed_load;
    logic [SUM_W-1:0] combined_smoothed_load;
    logic             critical_phase;
    logic             below_loading_margin;
    logic             entry_pushed;
  } result_t;

  // request handed from the group accumulator to the history unit
  typedef struct packed {
    logic             cluster_sel;
    logic             pushed;
    logic [SUM_W-1:0] group_sum;
    logic             group_critical;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/cluster_load_history_monitor.sv */
`timescale 1ns / 1ps
`default_nettype none

// Cluster load history monitor. Each sample (cluster select, core load) is
// added to its cluster's running group; every GROUP_SIZE samples of a cluster
// the group sum and its critical flag (any sample above the cluster's critical
// margin) shift into that cluster's HISTORY_DEPTH-deep history. Every sample
// yields exactly one result, taken from the history after its own update:
// the mean of the cluster's newest four entries, the sum of both clusters'
// newest four entries divided by sixteen, and two phase flags ANDed over the
// newest window_length entries. One sample is taken per clock cycle unless the
// two-entry queue from the group accumulator to the history unit is full;
// results leave through a result register. Configuration is written through
// cfg_write/cfg_index/cfg_data while idle, a user rule not enforced by the block.
module cluster_load_history_monitor #(
  parameter int HISTORY_DEPTH = clhm_pkg::DEF_HISTORY_DEPTH,
  parameter int GROUP_SIZE    = clhm_pkg::DEF_GROUP_SIZE
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         sample_valid,
  output logic                              sample_stall,
  input  wire clhm_pkg::sample_t            sample,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output clhm_pkg::result_t                 result,
  input  wire logic                         cfg_write,
  input  wire clhm_pkg::cfg_index_t         cfg_index,
  input  wire logic [clhm_pkg::CFG_W-1:0]   cfg_data
);
  import clhm_pkg::*;

  logic [MARGIN_W-1:0]  little_margin;
  logic [MARGIN_W-1:0]  big_margin;
  logic [LMARGIN_W-1:0] loading_margin;
  logic [WIN_W-1:0]     window_length;

  logic accept;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  cmd_t front_cmd;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      little_margin  <= RST_CRIT_MARGIN;
      big_margin     <= RST_CRIT_MARGIN;
      loading_margin <= RST_LOAD_MARGIN;
      window_length  <= RST_WINDOW;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LITTLE_CRIT_MARGIN: little_margin  <= cfg_data[MARGIN_W-1:0];
        CFG_BIG_CRIT_MARGIN:    big_margin     <= cfg_data[MARGIN_W-1:0];
        CFG_LOADING_MARGIN:     loading_margin <= cfg_data[LMARGIN_W-1:0];
        CFG_WINDOW_LENGTH:      window_length  <= cfg_data[WIN_W-1:0];
      endcase
    end
  end

  assign sample_stall = q_full;
  assign accept       = sample_valid && !q_full;

  clhm_front #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample       (sample),
    .little_margin(little_margin),
    .big_margin   (big_margin),
    .cmd          (front_cmd)
  );

  clhm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  clhm_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_not_empty),
    .cmd           (q_head),
    .cmd_pop       (q_pop),
    .loading_margin(loading_margin),
    .window_length (window_length),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

endmodule

`default_nettype wire

/* hw/rtl/clhm_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module clhm_front #(
  parameter int GROUP_SIZE = clhm_pkg::DEF_GROUP_SIZE
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire clhm_pkg::sample_t                 sample,
  input  wire logic [clhm_pkg::MARGIN_W-1:0]     little_margin,
  input  wire logic [clhm_pkg::MARGIN_W-1:0]     big_margin,
  output clhm_pkg::cmd_t                         cmd
);
  import clhm_pkg::*;

  localparam int CNT_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

  logic [SUM_W-1:0] group_sum [2];
  logic [CNT_W-1:0] group_count [2];
  logic             group_crit [2];

  logic [MARGIN_W-1:0] margin;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;
  logic                crit_now;
  logic                last;

  always_comb begin
    margin   = sample.cluster_sel ? big_margin : little_margin;
    sum_wide = {1'b0, group_sum[sample.cluster_sel]} + (SUM_W+1)'(sample.core_load);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    crit_now = group_crit[sample.cluster_sel] | (sample.core_load > margin);
    last     = (group_count[sample.cluster_sel] == CNT_LAST);

    cmd.cluster_sel    = sample.cluster_sel;
    cmd.pushed         = last;
    cmd.group_sum      = sum_sat;
    cmd.group_critical = crit_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        group_sum[c]   <= '0;
        group_count[c] <= '0;
        group_crit[c]  <= 1'b0;
      end
    end else if (accept) begin
      if (last) begin
        // group complete: restart accumulation
        group_sum[sample.cluster_sel]   <= '0;
        group_count[sample.cluster_sel] <= '0;
        group_crit[sample.cluster_sel]  <= 1'b0;
      end else begin
        group_sum[sample.cluster_sel]   <= sum_sat;
        group_count[sample.cluster_sel] <= group_count[sample.cluster_sel] + 1'b1;
        group_crit[sample.cluster_sel]  <= crit_now;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/clhm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module clhm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire clhm_pkg::cmd_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output clhm_pkg::cmd_t       head
);
  import clhm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/clhm_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module clhm_back #(
  parameter int HISTORY_DEPTH = clhm_pkg::DEF_HISTORY_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  input  wire clhm_pkg::cmd_t                  cmd,
  output logic                                 cmd_pop,
  input  wire logic [clhm_pkg::LMARGIN_W-1:0]  loading_margin,
  input  wire logic [clhm_pkg::WIN_W-1:0]      window_length,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output clhm_pkg::result_t                    result
);
  import clhm_pkg::*;

  localparam int TAP_SUM_W = SUM_W + $clog2(SMOOTH_TAPS);

  logic [SUM_W-1:0] little_hist [HISTORY_DEPTH];
  logic [SUM_W-1:0] big_hist    [HISTORY_DEPTH];
  logic             little_crit [HISTORY_DEPTH];
  logic             big_crit    [HISTORY_DEPTH];

  logic [SUM_W-1:0] little_next [HISTORY_DEPTH];
  logic [SUM_W-1:0] big_next    [HISTORY_DEPTH];
  logic             lcrit_next  [HISTORY_DEPTH];
  logic             bcrit_next  [HISTORY_DEPTH];

  logic                 push_little;
  logic                 push_big;
  logic [TAP_SUM_W-1:0] little_taps;
  logic [TAP_SUM_W-1:0] big_taps;
  logic [TAP_SUM_W:0]   both_taps;
  logic [SUM_W:0]       pair_sum;
  logic                 crit_all;
  logic                 below_all;
  result_t              result_next;

  assign cmd_pop = cmd_valid && (!result_valid || !result_stall);

  always_comb begin
    push_little = cmd.pushed && !cmd.cluster_sel;
    push_big    = cmd.pushed && cmd.cluster_sel;

    // shift in the completed group, newest at entry 0
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (k == 0) begin
        little_next[k] = push_little ? cmd.group_sum : little_hist[k];
        lcrit_next[k]  = push_little ? cmd.group_critical : little_crit[k];
        big_next[k]    = push_big ? cmd.group_sum : big_hist[k];
        bcrit_next[k]  = push_big ? cmd.group_critical : big_crit[k];
      end else begin
        little_next[k] = push_little ? little_hist[k-1] : little_hist[k];
        lcrit_next[k]  = push_little ? little_crit[k-1] : little_crit[k];
        big_next[k]    = push_big ? big_hist[k-1] : big_hist[k];
        bcrit_next[k]  = push_big ? big_crit[k-1] : big_crit[k];
      end
    end

    little_taps = '0;
    big_taps    = '0;
    for (int k = 0; k < SMOOTH_TAPS; k++) begin
      little_taps = little_taps + TAP_SUM_W'(little_next[k]);
      big_taps    = big_taps + TAP_SUM_W'(big_next[k]);
    end
    both_taps = {1'b0, little_taps} + {1'b0, big_taps};

    // window past the depth covers every entry
    crit_all  = 1'b1;
    below_all = 1'b1;
    pair_sum  = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      pair_sum = {1'b0, little_next[k]} + {1'b0, big_next[k]};
      if (int'(window_length) > k) begin
        crit_all = crit_all & (cmd.cluster_sel ? bcrit_next[k] : lcrit_next[k]);
        if (pair_sum >= loading_margin) begin
          below_all = 1'b0;
        end
      end
    end

    result_next.smoothed_load = cmd.cluster_sel ? big_taps[TAP_SUM_W-1:2]
                                                : little_taps[TAP_SUM_W-1:2];
    result_next.combined_smoothed_load = SUM_W'(both_taps >> 4);
    result_next.critical_phase         = crit_all;
    result_next.below_loading_margin   = below_all;
    result_next.entry_pushed           = cmd.pushed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        little_hist[k] <= '0;
        big_hist[k]    <= '0;
        little_crit[k] <= 1'b0;
        big_crit[k]    <= 1'b0;
      end
    end else if (cmd_pop) begin
      little_hist <= little_next;
      big_hist    <= big_next;
      little_crit <= lcrit_next;
      big_crit    <= bcrit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd_pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

/* tb/clhm_checker.sv */
`timescale 1ns / 1ps

module clhm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  input  logic                            sample_stall,
  input  clhm_pkg::sample_t               sample,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  clhm_pkg::result_t               result,
  input  logic                            cfg_write,
  input  clhm_pkg::cfg_index_t            cfg_index,
  input  logic [clhm_pkg::CFG_W-1:0]      cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              checked,
  output int                              pushes,
  output int                              crit_hits,
  output int                              below_hits
);
  import clhm_pkg::*;

  localparam int DEPTH = DEF_HISTORY_DEPTH;
  localparam int GROUP = DEF_GROUP_SIZE;

  logic [SUM_W-1:0]     group_sum   [2];
  int                   group_count [2];
  logic                 group_crit  [2];
  logic [SUM_W-1:0]     load_hist   [2][DEPTH];
  logic                 crit_hist   [2][DEPTH];
  logic [MARGIN_W-1:0]  crit_margin [2];
  logic [LMARGIN_W-1:0] load_margin;
  logic [WIN_W-1:0]     window;

  result_t report_q[$];
  result_t want;

  task automatic clear_history();
    for (int c = 0; c < 2; c++) begin
      group_sum[c]   = '0;
      group_count[c] = 0;
      group_crit[c]  = 1'b0;
      for (int k = 0; k < DEPTH; k++) begin
        load_hist[c][k] = '0;
        crit_hist[c][k] = 1'b0;
      end
    end
    crit_margin[0] = RST_CRIT_MARGIN;
    crit_margin[1] = RST_CRIT_MARGIN;
    load_margin    = RST_LOAD_MARGIN;
    window         = RST_WINDOW;
  endtask

  // Update the group and history of the sample's cluster, then report.
  function automatic result_t next_report(sample_t s);
    result_t r;
    int      c;
    int      sum;
    int      win;
    int      four [2];
    bit      crit;
    bit      below;
    c   = s.cluster_sel;
    sum = group_sum[c] + s.core_load;
    if (sum > int'(SUM_MAX))
      sum = int'(SUM_MAX);
    group_sum[c] = sum[SUM_W-1:0];
    if (s.core_load > crit_margin[c])
      group_crit[c] = 1'b1;
    group_count[c]++;
    r.entry_pushed = 1'b0;
    if (group_count[c] >= GROUP) begin
      for (int k = DEPTH - 1; k > 0; k--) begin
        load_hist[c][k] = load_hist[c][k-1];
        crit_hist[c][k] = crit_hist[c][k-1];
      end
      load_hist[c][0] = group_sum[c];
      crit_hist[c][0] = group_crit[c];
      group_sum[c]    = '0;
      group_crit[c]   = 1'b0;
      group_count[c]  = 0;
      r.entry_pushed  = 1'b1;
    end
    win   = (window > DEPTH) ? DEPTH : int'(window);
    crit  = 1'b1;
    below = 1'b1;
    for (int k = 0; k < win; k++) begin
      crit = crit & crit_hist[c][k];
      if (int'(load_hist[0][k]) + int'(load_hist[1][k]) >= int'(load_margin))
        below = 1'b0;
    end
    for (int i = 0; i < 2; i++) begin
      four[i] = 0;
      for (int j = 0; j < SMOOTH_TAPS; j++)
        four[i] += load_hist[i][j];
    end
    r.smoothed_load          = SUM_W'(four[c] >> 2);
    r.combined_smoothed_load = SUM_W'((four[0] + four[1]) >> 4);
    r.critical_phase         = crit;
    r.below_loading_margin   = below;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned want_v, int unsigned got_v);
    errors++;
    if (errors <= 10)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_history();
      report_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_LITTLE_CRIT_MARGIN: crit_margin[0] = cfg_data[MARGIN_W-1:0];
          CFG_BIG_CRIT_MARGIN:    crit_margin[1] = cfg_data[MARGIN_W-1:0];
          CFG_LOADING_MARGIN:     load_margin    = cfg_data[LMARGIN_W-1:0];
          CFG_WINDOW_LENGTH:      window         = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      // a result can never belong to a request taken at the same edge
      if (result_valid && !result_stall) begin
        if (report_q.size() == 0) begin
          flag_mismatch("pending result count", 0, 1);
        end else begin
          want = report_q.pop_front();
          checked++;
          if (result.smoothed_load !== want.smoothed_load)
            flag_mismatch("smoothed_load", want.smoothed_load, result.smoothed_load);
          if (result.combined_smoothed_load !== want.combined_smoothed_load)
            flag_mismatch("combined_smoothed_load", want.combined_smoothed_load,
                          result.combined_smoothed_load);
          if (result.critical_phase !== want.critical_phase)
            flag_mismatch("critical_phase", want.critical_phase, result.critical_phase);
          if (result.below_loading_margin !== want.below_loading_margin)
            flag_mismatch("below_loading_margin", want.below_loading_margin,
                          result.below_loading_margin);
          if (result.entry_pushed !== want.entry_pushed)
            flag_mismatch("entry_pushed", want.entry_pushed, result.entry_pushed);
          pushes     += want.entry_pushed;
          crit_hits  += want.critical_phase;
          below_hits += want.below_loading_margin;
        end
      end
      if (sample_valid && !sample_stall)
        report_q.push_back(next_report(sample));
    end
    pending = report_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import clhm_pkg::*;

  logic             clk;
  logic             rst;
  logic             sample_valid;
  logic             sample_stall;
  sample_t          sample;
  logic             result_valid;
  logic             result_stall;
  result_t          result;
  logic             cfg_write;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int errors;
  int pending;
  int checked;
  int pushes;
  int crit_hits;
  int below_hits;
  int samples_sent;
  int settings_used;

  cluster_load_history_monitor u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  clhm_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .pushes       (pushes),
    .crit_hits    (crit_hits),
    .below_hits   (below_hits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_sample(input logic sel, input logic [LOAD_W-1:0] load);
    sample_t s;
    s.cluster_sel = sel;
    s.core_load   = load;
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      sample_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    wait (pending == 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] little_m, input logic [CFG_W-1:0] big_m,
                               input logic [CFG_W-1:0] load_m, input logic [CFG_W-1:0] win);
    logic [CFG_W-1:0] vals [4];
    vals = '{little_m, big_m, load_m, win};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= vals[i];
      cfg_write <= 1'b1;
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase(input int count);
    int done;
    int burst;
    int level;
    int sel_mode;
    logic sel;
    logic [LOAD_W-1:0] load;
    done = 0;
    while (done < count) begin
      burst    = $urandom_range(1, 24);
      level    = $urandom_range(0, 3);
      sel_mode = $urandom_range(0, 2);
      for (int i = 0; i < burst && done < count; i++) begin
        case (level)
          0:       load = LOAD_W'($urandom_range(0, 25));
          1:       load = LOAD_W'($urandom_range(0, 100));
          2:       load = LOAD_W'($urandom_range(85, 127));
          default: load = LOAD_W'($urandom_range(0, 127));
        endcase
        sel = (sel_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(sel_mode);
        send_sample(sel, load);
        done++;
      end
      idle_for(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8));
    end
  endtask

  // Receiver: random stall stretches, plus two long hold-offs that back up the block.
  initial begin
    int hold_left;
    int holds_made;
    int stall_run;
    int stall_pct;
    hold_left    = 0;
    holds_made   = 0;
    stall_run    = 0;
    stall_pct    = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_made < 2 && samples_sent >= 300 * (holds_made + 1)) begin
        hold_left = 60;
        holds_made++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(5, 40);
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            default: stall_pct = 70;
          endcase
        end
        stall_run--;
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    rst           = 1'b1;
    sample_valid  = 1'b0;
    sample        = '0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_LITTLE_CRIT_MARGIN;
    cfg_data      = '0;
    samples_sent  = 0;
    settings_used = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full critical group, then a single above-margin load in a group
    for (int i = 0; i < 4; i++)
      send_sample(1'b0, 7'd100);
    send_sample(1'b1, 7'd0);
    send_sample(1'b1, 7'd0);
    send_sample(1'b1, 7'd0);
    send_sample(1'b1, 7'd127);
    // just above and exactly at the critical margin
    send_sample(1'b0, 7'd91);
    send_sample(1'b0, 7'd90);
    send_sample(1'b0, 7'd0);
    send_sample(1'b0, 7'd127);
    for (int i = 0; i < 4; i++)
      send_sample(1'b1, 7'd127);
    settle();

    // empty window, then window past the history depth
    set_registers(10'd90, 10'd90, 10'd200, 10'd0);
    send_sample(1'b0, 7'd5);
    send_sample(1'b1, 7'd100);
    send_sample(1'b0, 7'd50);
    settle();
    set_registers(10'd90, 10'd90, 10'd200, 10'd15);
    send_sample(1'b1, 7'd1);
    send_sample(1'b0, 7'd64);
    send_sample(1'b1, 7'd127);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_registers(10'd0, 10'd100, 10'd800, 10'd10);
        1: set_registers(10'd100, 10'd0, 10'd0, 10'd0);
        2: set_registers(10'h3FF, 10'h3C0, 10'h3FF, 10'hF);
        3: set_registers(10'd90, 10'd90, 10'd200, 10'd3);
        4: set_registers(CFG_W'($urandom_range(50, 100)), CFG_W'($urandom_range(50, 100)),
                         CFG_W'($urandom_range(300, 800)), CFG_W'($urandom_range(1, 10)));
        default: set_registers(CFG_W'($urandom_range(0, 1023)),
                               CFG_W'($urandom_range(0, 1023)),
                               CFG_W'($urandom_range(0, 1023)),
                               CFG_W'($urandom_range(0, 15)));
      endcase
      random_phase(150);
      settle();
    end

    repeat (20) @(negedge clk);
    $display("Checked %0d results: %0d history pushes, %0d critical, %0d below loading margin",
             checked, pushes, crit_hits, below_hits);
    $display("Covered %0d register settings and two long output hold-offs", settings_used);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
